[hdl/wbs_pkg.sv]
// types and constants shared by the white blob steering unit
// no dependencies

package wbs_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LEVEL = 1'd1;

  localparam logic [11:0] IMAGE_WIDTH_RESET = 12'd640;
  localparam logic [7:0]  MATCH_LEVEL_RESET = 8'd255;

  // floor(x / 3) == (x * THIRD_MUL) >> THIRD_SHIFT for any 12-bit x
  localparam logic [11:0] THIRD_MUL   = 12'd2731;
  localparam int          THIRD_SHIFT = 13;

  localparam logic [1:0] DIR_STOP     = 2'd0;
  localparam logic [1:0] DIR_LEFT     = 2'd1;
  localparam logic [1:0] DIR_STRAIGHT = 2'd2;
  localparam logic [1:0] DIR_RIGHT    = 2'd3;

  localparam logic [4:0]        DRIVE_SPEED = 5'd20;
  localparam logic signed [5:0] TURN_LEFT   = 6'sd20;
  localparam logic signed [5:0] TURN_NONE   = 6'sd0;
  localparam logic signed [5:0] TURN_RIGHT  = -6'sd20;

  localparam logic [10:0] BOX_NONE = 11'h7ff;

  typedef struct packed {
    logic              blob_found;
    logic [1:0]        direction;
    logic [4:0]        forward_speed;
    logic signed [5:0] turn_rate;
    logic [10:0]       center_column;
    logic [10:0]       box_col_min;
    logic [10:0]       box_col_max;
    logic [10:0]       box_row_min;
    logic [10:0]       box_row_max;
  } result_t;

endpackage

[hdl/wbs_if.sv]
// valid/ready channels for pixels in and steering results out
// uses no package

interface wbs_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       end_of_line;
  logic       end_of_frame;

  modport source (output valid, red, green, blue, end_of_line, end_of_frame, input ready);
  modport sink (input valid, red, green, blue, end_of_line, end_of_frame, output ready);
endinterface

interface wbs_result_if;
  logic              valid;
  logic              ready;
  logic              blob_found;
  logic [1:0]        direction;
  logic [4:0]        forward_speed;
  logic signed [5:0] turn_rate;
  logic [10:0]       center_column;
  logic [10:0]       box_col_min;
  logic [10:0]       box_col_max;
  logic [10:0]       box_row_min;
  logic [10:0]       box_row_max;

  modport source (output valid, blob_found, direction, forward_speed, turn_rate,
                  center_column, box_col_min, box_col_max, box_row_min, box_row_max,
                  input ready);
  modport sink (input valid, blob_found, direction, forward_speed, turn_rate,
                center_column, box_col_min, box_col_max, box_row_min, box_row_max,
                output ready);
endinterface

[hdl/white_blob_steering_unit.sv]
// white blob steering unit: top level with pixel input register and result register
// after its last pixel transfer, a frame's result passes the pixel register and then the result register
// throughput: one pixel per cycle while the result side keeps up
// a pending result stalls the pixel register and the tracker until it is taken
// synchronous reset clears frame state and sets image_width 640, match_level 255
// depends on wbs_pkg, wbs_if and wbs_tracker

module white_blob_steering_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [wbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  wbs_pixel_if.sink                        pix,
  wbs_result_if.source                     res
);

  logic [11:0]      image_width;
  logic [7:0]       match_level;
  logic [10:0]      left_limit;
  logic [23:0]      width_prod;

  logic             stage_valid;
  logic [7:0]       stage_red;
  logic [7:0]       stage_green;
  logic [7:0]       stage_blue;
  logic             stage_eol;
  logic             stage_eof;

  logic             advance;
  logic             step;
  logic             emit;
  wbs_pkg::result_t result_next;

  logic             out_valid;
  wbs_pkg::result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= wbs_pkg::IMAGE_WIDTH_RESET;
      match_level <= wbs_pkg::MATCH_LEVEL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wbs_pkg::REG_IMAGE_WIDTH: image_width <= cfg_data;
        wbs_pkg::REG_MATCH_LEVEL: match_level <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // left threshold = image_width / 3, right threshold is twice that
  assign width_prod = 24'(image_width) * 24'(wbs_pkg::THIRD_MUL);

  always_ff @(posedge clk) begin
    left_limit <= width_prod[wbs_pkg::THIRD_SHIFT +: 11];
  end

  assign advance   = !out_valid || res.ready;
  assign pix.ready = !stage_valid || advance;
  assign step      = stage_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (pix.valid && pix.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      stage_red   <= pix.red;
      stage_green <= pix.green;
      stage_blue  <= pix.blue;
      stage_eol   <= pix.end_of_line;
      stage_eof   <= pix.end_of_frame;
    end
  end

  wbs_tracker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .red          (stage_red),
    .green        (stage_green),
    .blue         (stage_blue),
    .end_of_line  (stage_eol),
    .end_of_frame (stage_eof),
    .match_level  (match_level),
    .left_limit   (left_limit),
    .emit         (emit),
    .result       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.blob_found    = out_data.blob_found;
  assign res.direction     = out_data.direction;
  assign res.forward_speed = out_data.forward_speed;
  assign res.turn_rate     = out_data.turn_rate;
  assign res.center_column = out_data.center_column;
  assign res.box_col_min   = out_data.box_col_min;
  assign res.box_col_max   = out_data.box_col_max;
  assign res.box_row_min   = out_data.box_row_min;
  assign res.box_row_max   = out_data.box_row_max;

endmodule

[hdl/wbs_tracker.sv]
// raster position counters, bounding box of matching pixels and steering decision
// depends on wbs_pkg

module wbs_tracker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic             end_of_line,
  input  logic             end_of_frame,
  input  logic [7:0]       match_level,
  input  logic [10:0]      left_limit,
  output logic             emit,
  output wbs_pkg::result_t result
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int LCW = (CW > 11) ? CW : 11;
  localparam int LRW = (RW > 11) ? RW : 11;
  localparam int SW  = LCW + 1;
  localparam int KW  = (LCW > 12) ? LCW : 12;

  localparam logic [CW-1:0]  COL_LAST  = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0]  ROW_LAST  = RW'(MAX_HEIGHT - 1);
  localparam logic [LCW-1:0] LCOL_INIT = LCW'(wbs_pkg::BOX_NONE);
  localparam logic [LRW-1:0] LROW_INIT = LRW'(wbs_pkg::BOX_NONE);

  logic [CW-1:0]  column_counter;
  logic [RW-1:0]  row_counter;
  logic           seen_match;
  logic [LCW-1:0] least_column;
  logic [LCW-1:0] greatest_column;
  logic [LRW-1:0] least_row;
  logic [LRW-1:0] greatest_row;

  logic           match;
  logic [LCW-1:0] col_ext;
  logic [LRW-1:0] row_ext;
  logic           seen_match_next;
  logic [LCW-1:0] least_column_next;
  logic [LCW-1:0] greatest_column_next;
  logic [LRW-1:0] least_row_next;
  logic [LRW-1:0] greatest_row_next;
  logic [SW-1:0]  col_sum;
  logic [LCW-1:0] center;
  logic [KW-1:0]  center_k;
  logic [KW-1:0]  left_k;
  logic [KW-1:0]  right_k;

  assign match   = (red == match_level) && (green == match_level) && (blue == match_level);
  assign col_ext = LCW'(column_counter);
  assign row_ext = LRW'(row_counter);

  always_comb begin
    seen_match_next      = seen_match | match;
    least_column_next    = least_column;
    greatest_column_next = greatest_column;
    least_row_next       = least_row;
    greatest_row_next    = greatest_row;
    if (match) begin
      if (col_ext < least_column) least_column_next = col_ext;
      if (col_ext > greatest_column) greatest_column_next = col_ext;
      if (row_ext < least_row) least_row_next = row_ext;
      if (row_ext > greatest_row) greatest_row_next = row_ext;
    end
  end

  // steering from the box that includes the last pixel
  assign col_sum  = SW'(least_column_next) + SW'(greatest_column_next);
  assign center   = col_sum[SW-1:1];
  assign center_k = KW'(center);
  assign left_k   = KW'(left_limit);
  assign right_k  = KW'({left_limit, 1'b0});

  always_comb begin
    result = '0;
    result.direction = wbs_pkg::DIR_STOP;
    if (seen_match_next) begin
      result.blob_found    = 1'b1;
      result.forward_speed = wbs_pkg::DRIVE_SPEED;
      result.center_column = 11'(center);
      result.box_col_min   = 11'(least_column_next);
      result.box_col_max   = 11'(greatest_column_next);
      result.box_row_min   = 11'(least_row_next);
      result.box_row_max   = 11'(greatest_row_next);
      if (center_k <= left_k) begin
        result.direction = wbs_pkg::DIR_LEFT;
        result.turn_rate = wbs_pkg::TURN_LEFT;
      end else if (center_k <= right_k) begin
        result.direction = wbs_pkg::DIR_STRAIGHT;
        result.turn_rate = wbs_pkg::TURN_NONE;
      end else begin
        result.direction = wbs_pkg::DIR_RIGHT;
        result.turn_rate = wbs_pkg::TURN_RIGHT;
      end
    end
  end

  assign emit = step && end_of_frame;

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_frame)) begin
      column_counter  <= '0;
      row_counter     <= '0;
      seen_match      <= 1'b0;
      least_column    <= LCOL_INIT;
      greatest_column <= '0;
      least_row       <= LROW_INIT;
      greatest_row    <= '0;
    end else if (step) begin
      seen_match      <= seen_match_next;
      least_column    <= least_column_next;
      greatest_column <= greatest_column_next;
      least_row       <= least_row_next;
      greatest_row    <= greatest_row_next;
      if (end_of_line) begin
        column_counter <= '0;
        if (row_counter < ROW_LAST) row_counter <= row_counter + RW'(1);
      end else if (column_counter < COL_LAST) begin
        column_counter <= column_counter + CW'(1);
      end
    end
  end

endmodule
